>>> rtl/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, codes and helpers shared by the three-component vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 17;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_CROSS = 3'd4,
    MODE_MAG   = 3'd5,
    MODE_NORM  = 3'd6
  } mode_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] res_scalar;
    logic               saturated;
    logic               zero_length;
  } out_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_s;
    logic               sat;
  } side_t;

  // truncate toward zero by 2^16 when asked, then clamp to 32 bits; msb is the clamp flag
  function automatic logic [32:0] sat_trunc(input logic signed [65:0] v, input logic shift);
    logic signed [65:0] t;
    logic [32:0]        r;
    if (shift) begin
      t = (v + (v[65] ? 66'sd65535 : 66'sd0)) >>> 16;
    end else begin
      t = v;
    end
    if (t > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (t < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, t[31:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/v3a_sqrt.sv
// ----------------------------------------------------------------------------
// v3a_sqrt
// Pipelined floored square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module v3a_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    n_i,
  input  v3a_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output v3a_pkg::side_t side_o
);
  import v3a_pkg::*;

  logic        valid_q [SQRT_STEPS];
  logic [33:0] rem_q   [SQRT_STEPS];
  logic [31:0] root_q  [SQRT_STEPS];
  logic [63:0] n_q     [SQRT_STEPS];
  side_t       side_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic        valid_p;
    logic [33:0] rem_p;
    logic [31:0] root_p;
    logic [63:0] n_p;
    side_t       side_p;
    logic [35:0] r2;
    logic [35:0] test;
    logic        ge;

    if (k == 0) begin : g_first
      assign valid_p = valid_i;
      assign rem_p   = '0;
      assign root_p  = '0;
      assign n_p     = n_i;
      assign side_p  = side_i;
    end else begin : g_next
      assign valid_p = valid_q[k-1];
      assign rem_p   = rem_q[k-1];
      assign root_p  = root_q[k-1];
      assign n_p     = n_q[k-1];
      assign side_p  = side_q[k-1];
    end

    assign r2   = {rem_p, n_p[63:62]};
    assign test = {2'b00, root_p, 2'b01};
    assign ge   = (r2 >= test);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? 34'(r2 - test) : r2[33:0];
        root_q[k] <= {root_p[30:0], ge};
        n_q[k]    <= {n_p[61:0], 2'b00};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

>>> rtl/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div
// Pipelined three-lane divide of |a| * 2^16 by a shared divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module v3a_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [31:0]    m_i,
  input  v3a_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    m_o,
  output logic [16:0]    q_o [3],
  output v3a_pkg::side_t side_o
);
  import v3a_pkg::*;

  logic        valid_q [DIV_STEPS];
  logic [31:0] m_q     [DIV_STEPS];
  side_t       side_q  [DIV_STEPS];
  logic [31:0] rem_q   [DIV_STEPS][3];
  logic [16:0] low_q   [DIV_STEPS][3];
  logic [16:0] q_q     [DIV_STEPS][3];

  logic [31:0] mag [3];

  always_comb begin
    mag[0] = side_i.a_x[31] ? 32'(-side_i.a_x) : side_i.a_x;
    mag[1] = side_i.a_y[31] ? 32'(-side_i.a_y) : side_i.a_y;
    mag[2] = side_i.a_z[31] ? 32'(-side_i.a_z) : side_i.a_z;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        valid_p;
    logic [31:0] m_p;
    side_t       side_p;

    if (k == 0) begin : g_first
      assign valid_p = valid_i;
      assign m_p     = m_i;
      assign side_p  = side_i;
    end else begin : g_next
      assign valid_p = valid_q[k-1];
      assign m_p     = m_q[k-1];
      assign side_p  = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k]    <= m_p;
        side_q[k] <= side_p;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [31:0] rem_p;
      logic [16:0] low_p;
      logic [16:0] q_p;
      logic [32:0] r2;
      logic        ge;

      if (k == 0) begin : g_first
        assign rem_p = {1'b0, mag[l][31:1]};
        assign low_p = {mag[l][0], 16'h0000};
        assign q_p   = '0;
      end else begin : g_next
        assign rem_p = rem_q[k-1][l];
        assign low_p = low_q[k-1][l];
        assign q_p   = q_q[k-1][l];
      end

      assign r2 = {rem_p, low_p[16]};
      assign ge = (r2 >= {1'b0, m_p});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? 32'(r2 - {1'b0, m_p}) : r2[31:0];
          low_q[k][l] <= {low_p[15:0], 1'b0};
          q_q[k][l]   <= {q_p[15:0], ge};
        end
      end
    end
  end

  assign valid_o = valid_q[DIV_STEPS-1];
  assign m_o     = m_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];
  assign q_o[0]  = q_q[DIV_STEPS-1][0];
  assign q_o[1]  = q_q[DIV_STEPS-1][1];
  assign q_o[2]  = q_q[DIV_STEPS-1][2];

endmodule

>>> rtl/vector3_alu_core.sv
// ----------------------------------------------------------------------------
// vector3_alu_core
// Q16.16 three-component vector unit: add, subtract, scale, dot, cross,
// magnitude and normalize, fully pipelined.
// ----------------------------------------------------------------------------
// Every mode passes the same stages from input beat to result beat.
// Throughput: one beat per cycle while the output is not stalled; the 32-stage
//   square root and the 17-stage divider are unrolled pipelines, one bit per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module vector3_alu_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  v3a_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output v3a_pkg::out_t out_data_o
);
  import v3a_pkg::*;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: operand select
  logic signed [31:0] opa_d [6];
  logic signed [31:0] opb_d [6];
  logic signed [31:0] opa_q [6];
  logic signed [31:0] opb_q [6];
  side_t              side1_d, side1_q;
  logic               s1_valid_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      opa_d[i] = '0;
      opb_d[i] = '0;
    end
    case (in_data_i.mode)
      MODE_ADD, MODE_SUB, MODE_DOT: begin
        opa_d[0] = in_data_i.a_x; opb_d[0] = in_data_i.b_x;
        opa_d[2] = in_data_i.a_y; opb_d[2] = in_data_i.b_y;
        opa_d[4] = in_data_i.a_z; opb_d[4] = in_data_i.b_z;
      end
      MODE_SCALE: begin
        opa_d[0] = in_data_i.a_x; opb_d[0] = in_data_i.factor;
        opa_d[2] = in_data_i.a_y; opb_d[2] = in_data_i.factor;
        opa_d[4] = in_data_i.a_z; opb_d[4] = in_data_i.factor;
      end
      MODE_CROSS: begin
        opa_d[0] = in_data_i.a_y; opb_d[0] = in_data_i.b_z;
        opa_d[1] = in_data_i.a_z; opb_d[1] = in_data_i.b_y;
        opa_d[2] = in_data_i.a_z; opb_d[2] = in_data_i.b_x;
        opa_d[3] = in_data_i.a_x; opb_d[3] = in_data_i.b_z;
        opa_d[4] = in_data_i.a_x; opb_d[4] = in_data_i.b_y;
        opa_d[5] = in_data_i.a_y; opb_d[5] = in_data_i.b_x;
      end
      MODE_MAG, MODE_NORM: begin
        opa_d[0] = in_data_i.a_x; opb_d[0] = in_data_i.a_x;
        opa_d[2] = in_data_i.a_y; opb_d[2] = in_data_i.a_y;
        opa_d[4] = in_data_i.a_z; opb_d[4] = in_data_i.a_z;
      end
      default: ;
    endcase
    side1_d      = '0;
    side1_d.mode = in_data_i.mode;
    side1_d.a_x  = in_data_i.a_x;
    side1_d.a_y  = in_data_i.a_y;
    side1_d.a_z  = in_data_i.a_z;
  end

  // stage 2: products, or sums for add and subtract
  logic signed [63:0] prod_d [6];
  logic signed [63:0] prod_q [6];
  side_t              side2_q;
  logic               s2_valid_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (side1_q.mode == MODE_ADD) begin
        prod_d[i] = 64'(opa_q[i]) + 64'(opb_q[i]);
      end else if (side1_q.mode == MODE_SUB) begin
        prod_d[i] = 64'(opa_q[i]) - 64'(opb_q[i]);
      end else begin
        prod_d[i] = 64'(opa_q[i]) * 64'(opb_q[i]);
      end
    end
  end

  // stage 3: combine
  logic signed [65:0] v_d [4];
  logic signed [65:0] v_q [4];
  side_t              side3_q;
  logic               s3_valid_q;

  always_comb begin
    v_d[0] = 66'(prod_q[0]) - 66'(prod_q[1]);
    v_d[1] = 66'(prod_q[2]) - 66'(prod_q[3]);
    v_d[2] = 66'(prod_q[4]) - 66'(prod_q[5]);
    v_d[3] = 66'(prod_q[0]) + 66'(prod_q[2]) + 66'(prod_q[4]);
  end

  // stage 4: truncate and clamp
  side_t       side4_d, side4_q;
  logic [63:0] n4_q;
  logic        s4_valid_q;
  logic [32:0] fin [4];
  logic        shift;

  always_comb begin
    shift = (side3_q.mode != MODE_ADD) && (side3_q.mode != MODE_SUB);
    for (int i = 0; i < 4; i++) begin
      fin[i] = sat_trunc(v_q[i], shift);
    end
    side4_d = side3_q;
    case (side3_q.mode)
      MODE_ADD, MODE_SUB, MODE_SCALE, MODE_CROSS: begin
        side4_d.r_x = fin[0][31:0];
        side4_d.r_y = fin[1][31:0];
        side4_d.r_z = fin[2][31:0];
        side4_d.sat = fin[0][32] | fin[1][32] | fin[2][32];
      end
      MODE_DOT: begin
        side4_d.r_s = fin[3][31:0];
        side4_d.sat = fin[3][32];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      opa_q   <= opa_d;
      opb_q   <= opb_d;
      side1_q <= side1_d;
      prod_q  <= prod_d;
      side2_q <= side1_q;
      v_q     <= v_d;
      side3_q <= side2_q;
      side4_q <= side4_d;
      n4_q    <= v_q[3][63:0];
    end
  end

  // square root and divide
  logic        sq_valid;
  logic [31:0] sq_root;
  side_t       sq_side;
  logic        dv_valid;
  logic [31:0] dv_m;
  logic [16:0] dv_q [3];
  side_t       dv_side;

  v3a_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s4_valid_q),
    .n_i     (n4_q),
    .side_i  (side4_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  v3a_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_valid),
    .m_i     (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .m_o     (dv_m),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  // output stage
  out_t out_d, out_q;
  logic out_valid_q;

  always_comb begin
    out_d.res_x       = dv_side.r_x;
    out_d.res_y       = dv_side.r_y;
    out_d.res_z       = dv_side.r_z;
    out_d.res_scalar  = dv_side.r_s;
    out_d.saturated   = dv_side.sat;
    out_d.zero_length = 1'b0;
    case (dv_side.mode)
      MODE_MAG: begin
        out_d.res_scalar = dv_m[31] ? 32'h7fff_ffff : dv_m;
        out_d.saturated  = dv_m[31];
      end
      MODE_NORM: begin
        if (dv_m == '0) begin
          out_d.zero_length = 1'b1;
        end else begin
          out_d.res_x = dv_side.a_x[31] ? -32'(dv_q[0]) : 32'(dv_q[0]);
          out_d.res_y = dv_side.a_y[31] ? -32'(dv_q[1]) : 32'(dv_q[1]);
          out_d.res_z = dv_side.a_z[31] ? -32'(dv_q[2]) : 32'(dv_q[2]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_zl_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      !out_data_o.saturated && out_data_o.res_x == '0 && out_data_o.res_y == '0 &&
      out_data_o.res_z == '0 && out_data_o.res_scalar == '0)
    else $error("zero-length result carries data");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.res_scalar == '0 ||
      (out_data_o.res_x == '0 && out_data_o.res_y == '0 && out_data_o.res_z == '0))
    else $error("scalar and vector results both set");

  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid && dv_side.mode == MODE_NORM && dv_m != '0 |->
      dv_q[0] <= 17'h10000 && dv_q[1] <= 17'h10000 && dv_q[2] <= 17'h10000)
    else $error("normalized component above one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s4_valid_q) && $stable(dv_valid))
    else $error("pipeline moved during stall");

endmodule
